@@ src/ifmt_pkg.sv @@
// Shared types, constants and a helper function for the integer field formatter.
package ifmt_pkg;

   // Widest field the block will produce; wider requests are clipped to it.
   localparam int MAX_FIELD_WIDTH = 63;
   localparam int WIDTH_BITS      = 6;
   localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_CODE = WIDTH_BITS'(MAX_FIELD_WIDTH);

   // Decimal digits needed for a 32-bit magnitude.
   localparam int DEC_DIGITS = 10;

   // ASCII codes used for padding, the sign and the digit glyphs.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_LOWER_A_LESS_TEN = 8'h57;

   // Conversion kinds carried by an item.
   typedef enum logic [1:0] {
      KIND_SDEC = 2'd0,
      KIND_UDEC = 2'd1,
      KIND_HEX  = 2'd2,
      KIND_CHAR = 2'd3
   } kind_type;

   // One request item as it arrives on the input channel.
   typedef struct packed {
      logic [1:0]            cmd;
      logic [31:0]           value;
      logic [WIDTH_BITS-1:0] field_width;
      logic                  align_left;
      logic                  pad_zeros;
   } req_item_type;

   // One result item: a single character of the field.
   typedef struct packed {
      logic [7:0] out_char;
      logic       is_last;
   } rsp_item_type;

   // A classified job as passed from the front end to the back end.
   typedef struct packed {
      kind_type              kind;
      logic [31:0]           mag;
      logic                  neg;
      logic [WIDTH_BITS-1:0] width;
      logic                  left;
      logic [7:0]            pad_char;
   } job_type;

   // Lowercase glyph for one hex or decimal digit.
   function automatic logic [7:0] digit_glyph(input logic [3:0] d);
      logic [7:0] ext;
      ext = {4'b0000, d};
      if (d < 4'd10) begin
         digit_glyph = CHAR_ZERO + ext;
      end else begin
         digit_glyph = CHAR_LOWER_A_LESS_TEN + ext;
      end
   endfunction

endpackage

@@ src/ifmt_front.sv @@
// Front end: accepts request items and classifies them into jobs for the queue.
module ifmt_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ifmt_pkg::req_item_type req_item,
   input  logic                  queue_full,
   output logic                  push_valid,
   output ifmt_pkg::job_type     push_job
);

   ifmt_pkg::kind_type kind;
   logic               negative;

   // An item is taken whenever the queue has room.
   assign req_ready  = !queue_full;
   assign push_valid = req_valid && !queue_full;

   // Classify the item: sign, magnitude, clipped width and pad character.
   always_comb begin
      kind     = ifmt_pkg::kind_type'(req_item.cmd);
      negative = (kind == ifmt_pkg::KIND_SDEC) && req_item.value[31];

      push_job.kind = kind;
      push_job.neg  = negative;
      push_job.mag  = negative ? (~req_item.value + 32'd1) : req_item.value;
      push_job.left = req_item.align_left;

      if (req_item.field_width > ifmt_pkg::MAX_WIDTH_CODE) begin
         push_job.width = ifmt_pkg::MAX_WIDTH_CODE;
      end else begin
         push_job.width = req_item.field_width;
      end

      if (req_item.pad_zeros && !req_item.align_left) begin
         push_job.pad_char = ifmt_pkg::CHAR_ZERO;
      end else begin
         push_job.pad_char = ifmt_pkg::CHAR_SPACE;
      end
   end

endmodule

@@ src/ifmt_job_queue.sv @@
// Two-entry job queue that decouples the front end from the back end.
module ifmt_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  ifmt_pkg::job_type push_job,
   output logic              full,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ifmt_pkg::job_type pop_job
);

   ifmt_pkg::job_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage; no reset needed as occupancy guards every read.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ src/ifmt_back.sv @@
// Back end: converts a job to digits and emits the padded field one item per character.
module ifmt_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  ifmt_pkg::job_type     job,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ifmt_pkg::rsp_item_type rsp_item
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIZE,
      ST_EMIT
   } state_type;

   state_type                              state_ff, state_in;
   ifmt_pkg::job_type                      job_ff, job_in;
   logic [ifmt_pkg::DEC_DIGITS-1:0][3:0]   digits_ff, digits_in;
   logic [31:0]                            shreg_ff, shreg_in;
   logic [4:0]                             bit_cnt_ff, bit_cnt_in;
   logic [3:0]                             ndig_ff, ndig_in;
   logic [3:0]                             len_ff, len_in;
   logic [ifmt_pkg::WIDTH_BITS-1:0]        total_ff, total_in;
   logic [ifmt_pkg::WIDTH_BITS-1:0]        padn_ff, padn_in;
   logic [ifmt_pkg::WIDTH_BITS-1:0]        pos_ff, pos_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   ifmt_pkg::rsp_item_type                 rsp_ff, rsp_in;

   logic [ifmt_pkg::DEC_DIGITS-1:0][3:0]   adjusted;
   logic [3:0]                             ndig_calc;
   logic [3:0]                             len_calc;
   logic [ifmt_pkg::WIDTH_BITS-1:0]        len_ext;
   logic [ifmt_pkg::WIDTH_BITS-1:0]        total_calc;
   logic                                   slot_free;
   logic                                   in_content;
   logic [ifmt_pkg::WIDTH_BITS-1:0]        ci_wide;
   logic [3:0]                             ci;
   logic [3:0]                             digit_off;
   logic [3:0]                             digit_idx;
   logic [7:0]                             emit_char;
   logic                                   emit_last;

   assign job_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Shift-and-add-three step: bump every BCD digit of five or more.
   always_comb begin
      for (int i = 0; i < ifmt_pkg::DEC_DIGITS; i++) begin
         adjusted[i] = (digits_ff[i] >= 4'd5) ? (digits_ff[i] + 4'd3) : digits_ff[i];
      end
   end

   // Count significant digits; a zero value still has one digit.
   always_comb begin
      ndig_calc = 4'd1;
      for (int i = 1; i < ifmt_pkg::DEC_DIGITS; i++) begin
         if (digits_ff[i] != 4'd0) begin
            ndig_calc = 4'(i + 1);
         end
      end
      if (job_ff.kind == ifmt_pkg::KIND_CHAR) begin
         len_calc = 4'd1;
      end else begin
         len_calc = ndig_calc + {3'b000, job_ff.neg};
      end
      len_ext    = {2'b00, len_calc};
      total_calc = (job_ff.width > len_ext) ? job_ff.width : len_ext;
   end

   // Character at the current field position.
   always_comb begin
      if (job_ff.left) begin
         in_content = (pos_ff < {2'b00, len_ff});
         ci_wide    = pos_ff;
      end else begin
         in_content = (pos_ff >= padn_ff);
         ci_wide    = pos_ff - padn_ff;
      end
      ci        = ci_wide[3:0];
      digit_off = ci - {3'b000, job_ff.neg};
      digit_idx = ndig_ff - 4'd1 - digit_off;

      if (!in_content) begin
         emit_char = job_ff.pad_char;
      end else if (job_ff.kind == ifmt_pkg::KIND_CHAR) begin
         emit_char = job_ff.mag[7:0];
      end else if (job_ff.neg && (ci == 4'd0)) begin
         emit_char = ifmt_pkg::CHAR_MINUS;
      end else begin
         emit_char = ifmt_pkg::digit_glyph(digits_ff[digit_idx]);
      end
      emit_last = (pos_ff == total_ff - 6'd1);
   end

   // Sequencer: take a job, convert, size the field, then emit it.
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      digits_in    = digits_ff;
      shreg_in     = shreg_ff;
      bit_cnt_in   = bit_cnt_ff;
      ndig_in      = ndig_ff;
      len_in       = len_ff;
      total_in     = total_ff;
      padn_in      = padn_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_in     = job;
               shreg_in   = job.mag;
               bit_cnt_in = 5'd0;
               if ((job.kind == ifmt_pkg::KIND_SDEC) || (job.kind == ifmt_pkg::KIND_UDEC)) begin
                  digits_in = '0;
                  state_in  = ST_CONV;
               end else begin
                  digits_in = {8'h00, job.mag};
                  state_in  = ST_SIZE;
               end
            end
         end
         ST_CONV: begin
            // The top digit never exceeds four, so its high bit can be dropped.
            digits_in  = {adjusted[ifmt_pkg::DEC_DIGITS-1][2:0],
                          adjusted[ifmt_pkg::DEC_DIGITS-2:0], shreg_ff[31]};
            shreg_in   = {shreg_ff[30:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 5'd1;
            if (bit_cnt_ff == 5'd31) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            ndig_in  = ndig_calc;
            len_in   = len_calc;
            total_in = total_calc;
            padn_in  = total_calc - len_ext;
            pos_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.out_char = emit_char;
               rsp_in.is_last  = emit_last;
               pos_in          = pos_ff + 6'd1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff     <= job_in;
      digits_ff  <= digits_in;
      shreg_ff   <= shreg_in;
      bit_cnt_ff <= bit_cnt_in;
      ndig_ff    <= ndig_in;
      len_ff     <= len_in;
      total_ff   <= total_in;
      padn_ff    <= padn_in;
      pos_ff     <= pos_in;
      rsp_ff     <= rsp_in;
   end

endmodule

@@ src/integer_field_formatter_core.sv @@
// Top level of the integer field formatter: front end, job queue and back end.
//
// Each request item is one printf-style integer or character conversion; the block returns
// the characters of the padded field as result items, one character per item, with is_last
// set on the final one. The front end classifies an item in the cycle it is accepted and
// places it in a two-entry queue, so up to two further items can be taken while one is being
// formatted. The back end handles one item at a time: a decimal item is loaded, converted
// by shift-and-add-three over its 32-bit magnitude, the field is sized and then its
// characters are emitted in order, each held back while the result register is full and
// not taken; hex and character items skip the conversion. The result register lets the
// next character be prepared while the current one waits to be taken.
module integer_field_formatter_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ifmt_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ifmt_pkg::rsp_item_type rsp_item
);

   logic              push_valid;
   ifmt_pkg::job_type push_job;
   logic              queue_full;
   logic              pop_valid;
   logic              pop_ready;
   ifmt_pkg::job_type pop_job;

   // Classification of incoming items.
   ifmt_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   // Decoupling queue between the two halves.
   ifmt_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // Conversion and character emission.
   ifmt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job       (pop_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

@@ test/ifmt_field_checker.sv @@
// Checker for the integer field formatter: predicts each field's characters and compares results.
module ifmt_field_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  ifmt_pkg::req_item_type req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ifmt_pkg::rsp_item_type rsp_item,
   output int                     mismatch_count,
   output int                     pending_chars,
   output int                     fields_taken,
   output int                     chars_checked
);

   localparam logic [7:0] GLYPH_LOWER_A = 8'h61;

   // Characters still owed by the block, oldest first.
   ifmt_pkg::rsp_item_type expected_chars[$];
   ifmt_pkg::rsp_item_type want_char;

   initial begin
      mismatch_count = 0;
      pending_chars  = 0;
      fields_taken   = 0;
      chars_checked  = 0;
   end

   // Works out the full text of one field and queues it, marking the final character.
   function automatic void queue_field_text(input ifmt_pkg::req_item_type it);
      logic [7:0]  digits_rev[12];
      logic [7:0]  content[12];
      logic [7:0]  field_text[64];
      logic [31:0] mag;
      logic [31:0] radix;
      logic [31:0] digit;
      logic [7:0]  fill;
      ifmt_pkg::rsp_item_type ch;
      int len;
      int n;
      int width;
      int pad;
      int total;
      int k;
      len   = 0;
      n     = 0;
      radix = 32'd10;
      mag   = it.value;
      case (ifmt_pkg::kind_type'(it.cmd))
         ifmt_pkg::KIND_SDEC: begin
            if (it.value[31]) begin
               content[0] = ifmt_pkg::CHAR_MINUS;
               len = 1;
               mag = -it.value;
            end
         end
         ifmt_pkg::KIND_UDEC: radix = 32'd10;
         ifmt_pkg::KIND_HEX:  radix = 32'd16;
         default: begin
            content[0] = it.value[7:0];
            len = 1;
         end
      endcase
      // Numeric kinds: collect digits least significant first, then reverse them.
      if (ifmt_pkg::kind_type'(it.cmd) != ifmt_pkg::KIND_CHAR) begin
         do begin
            digit = mag % radix;
            digits_rev[n] = (digit < 32'd10) ? ifmt_pkg::CHAR_ZERO + digit[7:0]
                                             : GLYPH_LOWER_A + digit[7:0] - 8'd10;
            mag = mag / radix;
            n++;
         end while (mag != 32'd0);
         for (k = n - 1; k >= 0; k--) begin
            content[len] = digits_rev[k];
            len++;
         end
      end
      width = int'(it.field_width);
      if (width > ifmt_pkg::MAX_FIELD_WIDTH) begin
         width = ifmt_pkg::MAX_FIELD_WIDTH;
      end
      pad = (width > len) ? width - len : 0;
      fill = (it.pad_zeros && !it.align_left) ? ifmt_pkg::CHAR_ZERO : ifmt_pkg::CHAR_SPACE;
      // Padding goes in front unless the field is left-aligned.
      total = 0;
      if (!it.align_left) begin
         for (k = 0; k < pad; k++) begin
            field_text[total] = fill;
            total++;
         end
      end
      for (k = 0; k < len; k++) begin
         field_text[total] = content[k];
         total++;
      end
      if (it.align_left) begin
         for (k = 0; k < pad; k++) begin
            field_text[total] = fill;
            total++;
         end
      end
      for (k = 0; k < total; k++) begin
         ch.out_char = field_text[k];
         ch.is_last  = (k == total - 1);
         expected_chars.push_back(ch);
      end
   endfunction

   // Watch both channels: accepted items feed the prediction, accepted results are compared.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            queue_field_text(req_item);
            fields_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               mismatch_count++;
               $error("Unexpected character %h (is_last %b) with nothing outstanding",
                      rsp_item.out_char, rsp_item.is_last);
            end else begin
               want_char = expected_chars.pop_front();
               chars_checked++;
               if (rsp_item.out_char !== want_char.out_char) begin
                  mismatch_count++;
                  $error("out_char mismatch: expected %h, actual %h",
                         want_char.out_char, rsp_item.out_char);
               end
               if (rsp_item.is_last !== want_char.is_last) begin
                  mismatch_count++;
                  $error("is_last mismatch: expected %b, actual %b",
                         want_char.is_last, rsp_item.is_last);
               end
            end
         end
      end
      pending_chars = expected_chars.size();
   end

endmodule

@@ test/tb_integer_field_formatter_core.sv @@
// Testbench top for the integer field formatter: stimulus, pacing and the final verdict.
module tb_integer_field_formatter_core;

   localparam int RANDOM_PER_PHASE = 120;
   localparam int DRAIN_CYCLES     = 120;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   ifmt_pkg::req_item_type req_item;
   logic                   rsp_valid;
   logic                   rsp_ready;
   ifmt_pkg::rsp_item_type rsp_item;

   int mismatch_count;
   int pending_chars;
   int fields_taken;
   int chars_checked;
   int send_idle_pct;
   int recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   integer_field_formatter_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   ifmt_field_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item       (rsp_item),
      .mismatch_count (mismatch_count),
      .pending_chars  (pending_chars),
      .fields_taken   (fields_taken),
      .chars_checked  (chars_checked)
   );

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Hard stop in case the block hangs.
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   // Offers one item, with random idle cycles in front, and waits until it is taken.
   task automatic send_field(input ifmt_pkg::req_item_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic send_directed(input ifmt_pkg::kind_type kind, input logic [31:0] value,
                                input int width, input logic left, input logic zeros);
      ifmt_pkg::req_item_type it;
      it.cmd         = kind;
      it.value       = value;
      it.field_width = width[ifmt_pkg::WIDTH_BITS-1:0];
      it.align_left  = left;
      it.pad_zeros   = zeros;
      send_field(it);
   endtask

   // Random item biased towards values with awkward digit counts and sign boundaries.
   function automatic ifmt_pkg::req_item_type random_field();
      ifmt_pkg::req_item_type it;
      logic [31:0]            p;
      int                     pick;
      it.cmd = 2'($urandom_range(0, 3));
      pick   = $urandom_range(0, 9);
      case (pick)
         4: it.value = $urandom_range(0, 20);
         5: it.value = -$urandom_range(1, 20);
         6: it.value = 32'h8000_0000 + $urandom_range(0, 4) - 32'd2;
         7: it.value = 32'hFFFF_FFFF - $urandom_range(0, 3);
         8: begin
            p = 32'd1;
            repeat ($urandom_range(0, 9)) p = p * 32'd10;
            it.value = p + $urandom_range(0, 2) - 32'd1;
         end
         9: it.value = $urandom_range(0, 255);
         default: it.value = $urandom;
      endcase
      if ($urandom_range(0, 3) == 0) begin
         it.field_width = ifmt_pkg::WIDTH_BITS'($urandom_range(0, 63));
      end else begin
         it.field_width = ifmt_pkg::WIDTH_BITS'($urandom_range(0, 14));
      end
      it.align_left = 1'($urandom_range(0, 1));
      it.pad_zeros  = 1'($urandom_range(0, 1));
      return it;
   endfunction

   task automatic run_phase(input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (RANDOM_PER_PHASE) send_field(random_field());
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_item       = '0;
      rsp_ready      = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed cases: field extremes, every kind and the documented corner cases.
      send_directed(ifmt_pkg::KIND_SDEC, 32'd0,          0,  1'b0, 1'b0);
      send_directed(ifmt_pkg::KIND_SDEC, 32'h8000_0000,  0,  1'b0, 1'b0);
      send_directed(ifmt_pkg::KIND_SDEC, -32'sd5,        5,  1'b0, 1'b1);
      send_directed(ifmt_pkg::KIND_SDEC, -32'sd5,        5,  1'b1, 1'b1);
      send_directed(ifmt_pkg::KIND_SDEC, 32'h7FFF_FFFF,  63, 1'b0, 1'b0);
      send_directed(ifmt_pkg::KIND_SDEC, 32'hFFFF_FFFF,  2,  1'b0, 1'b0);
      send_directed(ifmt_pkg::KIND_SDEC, 32'd1234,       4,  1'b0, 1'b1);
      send_directed(ifmt_pkg::KIND_SDEC, 32'h8000_0000,  63, 1'b0, 1'b1);
      send_directed(ifmt_pkg::KIND_UDEC, 32'hFFFF_FFFF,  0,  1'b0, 1'b0);
      send_directed(ifmt_pkg::KIND_UDEC, 32'd0,          63, 1'b0, 1'b1);
      send_directed(ifmt_pkg::KIND_UDEC, 32'h8000_0000,  11, 1'b0, 1'b1);
      send_directed(ifmt_pkg::KIND_UDEC, 32'd42,         10, 1'b1, 1'b0);
      send_directed(ifmt_pkg::KIND_HEX,  32'hDEAD_BEEF,  10, 1'b0, 1'b1);
      send_directed(ifmt_pkg::KIND_HEX,  32'd0,          1,  1'b0, 1'b0);
      send_directed(ifmt_pkg::KIND_HEX,  32'hFFFF_FFFF,  63, 1'b1, 1'b0);
      send_directed(ifmt_pkg::KIND_HEX,  32'h0000_000A,  3,  1'b0, 1'b1);
      send_directed(ifmt_pkg::KIND_HEX,  32'h0123_4567,  8,  1'b1, 1'b1);
      send_directed(ifmt_pkg::KIND_CHAR, 32'hFFFF_FF00,  0,  1'b0, 1'b0);
      send_directed(ifmt_pkg::KIND_CHAR, 32'h0000_0041,  3,  1'b0, 1'b0);
      send_directed(ifmt_pkg::KIND_CHAR, 32'h1234_56FF,  63, 1'b1, 1'b1);
      send_directed(ifmt_pkg::KIND_CHAR, 32'h0000_007A,  4,  1'b0, 1'b1);

      // Random items under each pacing mix.
      run_phase(0,  0);
      run_phase(56, 0);
      run_phase(0,  56);
      run_phase(24, 24);

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_chars == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Formatted %0d fields of all four kinds; %0d characters checked.",
               fields_taken, chars_checked);
      $display("Pacing covered free running, sender gaps, receiver stalls and both together.");
      if (mismatch_count == 0 && pending_chars == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
